FILE: rtl/sm3_pkg.sv
`default_nettype none
// ============================================================================
// sm3_pkg
// Constants and helper functions shared by the SM3 byte-stream hash block.
// ============================================================================
package sm3_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CountWidth = 64;
   localparam int unsigned IndexWidth = 3;

   localparam logic CMD_ABSORB = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   localparam logic [WordWidth-1:0] SM3_IV [8] = '{
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
   };

   localparam logic [WordWidth-1:0] T_LOW  = 32'h79cc4519;
   localparam logic [WordWidth-1:0] T_HIGH = 32'h7a879d8a;
   localparam logic [ByteWidth-1:0] PAD_MARK = 8'h80;

   function automatic logic [WordWidth-1:0] rotl32(input logic [WordWidth-1:0] x,
                                                   input logic [4:0] k);
      logic [2*WordWidth-1:0] d;
      d = {x, x} << k;
      return d[2*WordWidth-1:WordWidth];
   endfunction

   function automatic logic [WordWidth-1:0] perm0(input logic [WordWidth-1:0] x);
      return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
   endfunction

   function automatic logic [WordWidth-1:0] perm1(input logic [WordWidth-1:0] x);
      return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
   endfunction

   // Round constant already rotated by (round mod 32)
   function automatic logic [WordWidth-1:0] t_rot(input logic [5:0] round);
      logic [WordWidth-1:0] t;
      t = (round < 6'd16) ? T_LOW : T_HIGH;
      return rotl32(t, round[4:0]);
   endfunction

endpackage
`default_nettype wire

FILE: rtl/sm3_channels.sv
`default_nettype none
// ============================================================================
// sm3_channels
// Valid/ready channel interfaces for the SM3 request and digest response.
// ============================================================================
interface sm3_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] data_byte;

   modport source (output valid, output command, output data_byte, input ready);
   modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface sm3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last;

   modport source (output valid, output digest_word, output word_index, output last,
                   input ready);
   modport sink   (input valid, input digest_word, input word_index, input last,
                   output ready);
endinterface
`default_nettype wire

FILE: rtl/sm3_hash_byte_stream.sv
`default_nettype none
// ============================================================================
// sm3_hash_byte_stream
// SM3 hash over a byte stream, one shared round unit under a small sequencer.
//
// Request channel (req_ch): command 0 absorbs data_byte, command 1 pads and
// finishes the message. Response channel (rsp_ch): eight digest words, most
// significant first, with word_index and last on the eighth word.
// An absorb shifts one byte into the message window; every 64th byte of a
// message also runs the compression, 64 rounds at one round per cycle. A
// finish shifts in the padding one byte a cycle: 0x80 and zeros up to byte
// 56 of the block (1 to 56 bytes); when fewer than 9 bytes remain the block
// is zero-filled and compressed first. Then come 8 length bytes and the 64
// rounds of the last block, after which the digest words are offered. The
// round unit works on the 16-word window that the byte shifter fills.
// req_ch.ready is high only while the block is idle.
// The digest is held while rsp_ch.ready is low; the next message starts
// after the last word is taken, with the chaining value back at the IV.
// Reset (synchronous) loads the IV, clears the bit count and returns to idle.
// ============================================================================
module sm3_hash_byte_stream (
   input  wire            clock,
   input  wire            reset,
   sm3_req_if.sink        req_ch,
   sm3_rsp_if.source      rsp_ch
);
   import sm3_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_PAD   = 5'b00010,
      S_LEN   = 5'b00100,
      S_ROUND = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   state_type              ret_ff, ret_in;
   logic [5:0]             round_ff, round_in;
   logic [IndexWidth-1:0]  out_idx_ff, out_idx_in;
   logic                   pad_first_ff, pad_first_in;
   logic [CountWidth-1:0]  bit_count_ff, bit_count_in;
   logic [CountWidth-1:0]  msg_bits_ff, msg_bits_in;
   logic [WordWidth-1:0]   chain_ff [8];
   logic [WordWidth-1:0]   chain_in [8];
   logic [WordWidth-1:0]   win_ff [16];
   logic [WordWidth-1:0]   win_in [16];
   logic [WordWidth-1:0]   v_ff [8];
   logic [WordWidth-1:0]   v_in [8];

   logic                   req_take;
   logic                   rsp_take;
   logic                   shift_en;
   logic [ByteWidth-1:0]   shift_byte;
   logic [5:0]             pos;

   // round datapath
   logic [WordWidth-1:0]   a12, ss1, ss2, ffv, ggv, tt1, tt2, w_new;
   logic [WordWidth-1:0]   v_next [8];

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = (state_ff == S_OUT);
   assign rsp_take     = rsp_ch.valid && rsp_ch.ready;
   assign rsp_ch.digest_word = chain_ff[out_idx_ff];
   assign rsp_ch.word_index  = out_idx_ff;
   assign rsp_ch.last        = (out_idx_ff == 3'd7);

   assign pos = bit_count_ff[8:3];

   always_comb begin
      a12   = rotl32(v_ff[0], 5'd12);
      ss1   = rotl32(a12 + v_ff[4] + t_rot(round_ff), 5'd7);
      ss2   = ss1 ^ a12;
      if (round_ff < 6'd16) begin
         ffv = v_ff[0] ^ v_ff[1] ^ v_ff[2];
         ggv = v_ff[4] ^ v_ff[5] ^ v_ff[6];
      end else begin
         ffv = (v_ff[0] & v_ff[1]) | (v_ff[0] & v_ff[2]) | (v_ff[1] & v_ff[2]);
         ggv = (v_ff[4] & v_ff[5]) | (~v_ff[4] & v_ff[6]);
      end
      tt1   = ffv + v_ff[3] + ss2 + (win_ff[0] ^ win_ff[4]);
      tt2   = ggv + v_ff[7] + ss1 + win_ff[0];
      w_new = perm1(win_ff[0] ^ win_ff[7] ^ rotl32(win_ff[13], 5'd15))
            ^ rotl32(win_ff[3], 5'd7) ^ win_ff[10];
      v_next[0] = tt1;
      v_next[1] = v_ff[0];
      v_next[2] = rotl32(v_ff[1], 5'd9);
      v_next[3] = v_ff[2];
      v_next[4] = perm0(tt2);
      v_next[5] = v_ff[4];
      v_next[6] = rotl32(v_ff[5], 5'd19);
      v_next[7] = v_ff[6];
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      round_in     = round_ff;
      out_idx_in   = out_idx_ff;
      pad_first_in = pad_first_ff;
      bit_count_in = bit_count_ff;
      msg_bits_in  = msg_bits_ff;
      chain_in     = chain_ff;
      win_in       = win_ff;
      v_in         = v_ff;
      shift_en     = 1'b0;
      shift_byte   = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_ch.command == CMD_ABSORB) begin
                  shift_en   = 1'b1;
                  shift_byte = req_ch.data_byte;
                  if (pos == 6'd63) begin
                     state_in = S_ROUND;
                     ret_in   = S_IDLE;
                  end
               end else begin
                  msg_bits_in  = bit_count_ff;
                  pad_first_in = 1'b1;
                  state_in     = S_PAD;
               end
            end
         end
         S_PAD: begin
            shift_en     = 1'b1;
            shift_byte   = pad_first_ff ? PAD_MARK : '0;
            pad_first_in = 1'b0;
            if (pos == 6'd63) begin
               // block full before the length fits: compress, then keep padding
               state_in = S_ROUND;
               ret_in   = S_PAD;
            end else if (pos == 6'd55) begin
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            shift_en    = 1'b1;
            shift_byte  = msg_bits_ff[CountWidth-1 -: ByteWidth];
            msg_bits_in = {msg_bits_ff[CountWidth-ByteWidth-1:0], {ByteWidth{1'b0}}};
            if (pos == 6'd63) begin
               state_in = S_ROUND;
               ret_in   = S_OUT;
            end
         end
         S_ROUND: begin
            v_in     = v_next;
            round_in = round_ff + 6'd1;
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[15] = w_new;
            if (round_ff == 6'd63) begin
               for (int i = 0; i < 8; i++) begin
                  chain_in[i] = chain_ff[i] ^ v_next[i];
               end
               state_in   = ret_ff;
               out_idx_in = '0;
            end
         end
         S_OUT: begin
            if (rsp_take) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == 3'd7) begin
                  chain_in     = SM3_IV;
                  bit_count_in = '0;
                  state_in     = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (shift_en) begin
         // byte-wide shift of the 512-bit window keeps words big-endian
         for (int i = 0; i < 15; i++) begin
            win_in[i] = {win_ff[i][WordWidth-ByteWidth-1:0],
                         win_ff[i+1][WordWidth-1 -: ByteWidth]};
         end
         win_in[15]   = {win_ff[15][WordWidth-ByteWidth-1:0], shift_byte};
         bit_count_in = bit_count_ff + 64'd8;
         if (pos == 6'd63) begin
            v_in     = chain_ff;
            round_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         round_ff     <= '0;
         out_idx_ff   <= '0;
         pad_first_ff <= 1'b0;
         bit_count_ff <= '0;
         chain_ff     <= SM3_IV;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         round_ff     <= round_in;
         out_idx_ff   <= out_idx_in;
         pad_first_ff <= pad_first_in;
         bit_count_ff <= bit_count_in;
         chain_ff     <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_bits_ff <= msg_bits_in;
      win_ff      <= win_in;
      v_ff        <= v_in;
   end

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("request accepted while digest pending");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.last) |=> !rsp_ch.valid)
      else $error("response valid after last word");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.last) |=>
         (rsp_ch.word_index == 3'($past(rsp_ch.word_index) + 3'd1)))
      else $error("digest word index skipped");

   a_rounds_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND && round_ff == 6'd63) |=> state_ff != S_ROUND)
      else $error("compression ran past 64 rounds");

   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.last) |=> bit_count_ff == '0)
      else $error("bit count not cleared after digest");

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// SM3 byte-stream hash testbench
// Byte messages of assorted lengths are sent on the request channel. A
// bit-accurate SM3 model in the bench predicts the eight digest words of each
// finish. Every digest transaction is checked in order against that model.
// ============================================================================
module testbench;
   import sm3_pkg::*;

   localparam int unsigned IdleLimit   = 4000;  // cycles with no transaction at all
   localparam int unsigned DrainCycles = 300;
   localparam int unsigned CalmItems   = 50;    // final stretch runs without gaps
   localparam int unsigned HoldCycles  = 400;
   localparam int unsigned RandomItems = 380;

   localparam logic [8:0]  LengthSlot    = 9'd448;
   localparam logic [7:0]  PadByte       = 8'h80;
   localparam logic [31:0] RoundConstLow  = 32'h79cc4519;
   localparam logic [31:0] RoundConstHigh = 32'h7a879d8a;
   localparam logic [31:0] InitChain [8] = '{
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
   };

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } byte_req_t;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last;
   } digest_beat_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sm3_req_if req_ch();
   sm3_rsp_if rsp_ch();

   sm3_hash_byte_stream dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #1 clock = ~clock;

   // hash model state
   logic [31:0] chain_st [8];
   logic [31:0] msg_words [16];
   logic [63:0] msg_bits;

   byte_req_t    pending [$];
   digest_beat_t digest_q [$];

   logic        req_fire = 1'b0;
   logic        failed = 1'b0;
   logic        pressure_done = 1'b0;
   int unsigned accepted_reqs = 0;
   int unsigned idle_cycles = 0;
   int unsigned send_gap = 0;
   int unsigned recv_gap = 0;
   int unsigned hold_left = 0;

   function automatic logic [31:0] rot_left(input logic [31:0] x, input int unsigned k);
      int unsigned s;
      s = k % 32;
      if (s == 0) return x;
      return (x << s) | (x >> (32 - s));
   endfunction

   function automatic logic [31:0] mix0(input logic [31:0] x);
      return x ^ rot_left(x, 9) ^ rot_left(x, 17);
   endfunction

   function automatic logic [31:0] mix1(input logic [31:0] x);
      return x ^ rot_left(x, 15) ^ rot_left(x, 23);
   endfunction

   function automatic void compress_block();
      logic [31:0] w [68];
      logic [31:0] wx [64];
      logic [31:0] v [8];
      logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;
      for (int j = 0; j < 16; j++) w[j] = msg_words[j];
      for (int j = 16; j < 68; j++)
         w[j] = mix1(w[j-16] ^ w[j-9] ^ rot_left(w[j-3], 15)) ^ rot_left(w[j-13], 7) ^ w[j-6];
      for (int j = 0; j < 64; j++) wx[j] = w[j] ^ w[j+4];
      for (int j = 0; j < 8; j++) v[j] = chain_st[j];
      for (int j = 0; j < 64; j++) begin
         tj  = (j < 16) ? RoundConstLow : RoundConstHigh;
         a12 = rot_left(v[0], 12);
         ss1 = rot_left(a12 + v[4] + rot_left(tj, j), 7);
         ss2 = ss1 ^ a12;
         if (j < 16) begin
            ff = v[0] ^ v[1] ^ v[2];
            gg = v[4] ^ v[5] ^ v[6];
         end else begin
            ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
            gg = (v[4] & v[5]) | (~v[4] & v[6]);
         end
         tt1 = ff + v[3] + ss2 + wx[j];
         tt2 = gg + v[7] + ss1 + w[j];
         v[3] = v[2];
         v[2] = rot_left(v[1], 9);
         v[1] = v[0];
         v[0] = tt1;
         v[7] = v[6];
         v[6] = rot_left(v[5], 19);
         v[5] = v[4];
         v[4] = mix0(tt2);
      end
      for (int j = 0; j < 8; j++) chain_st[j] = chain_st[j] ^ v[j];
   endfunction

   // big-endian byte lanes; a full 512-bit block compresses at once
   function automatic void absorb_byte(input logic [7:0] b);
      int unsigned lane;
      lane = 3 - msg_bits[4:3];
      msg_words[msg_bits[8:5]][lane*8 +: 8] = b;
      msg_bits = msg_bits + 64'd8;
      if (msg_bits[8:0] == 9'd0) compress_block();
   endfunction

   function automatic void hash_step(input byte_req_t item);
      logic [63:0]  length_bits;
      digest_beat_t beat;
      if (item.command == CMD_ABSORB) begin
         absorb_byte(item.data_byte);
         return;
      end
      length_bits = msg_bits;
      absorb_byte(PadByte);
      // spills into a second block when the length no longer fits
      while (msg_bits[8:0] != LengthSlot) absorb_byte(8'h00);
      msg_words[14] = length_bits[63:32];
      msg_words[15] = length_bits[31:0];
      compress_block();
      for (int k = 0; k < 8; k++) begin
         beat.digest_word = chain_st[k];
         beat.word_index  = 3'(k);
         beat.last        = (k == 7);
         digest_q.push_back(beat);
      end
      chain_st = InitChain;
      msg_bits = '0;
   endfunction

   function automatic void note_mismatch(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      failed = 1'b1;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
   endfunction

   function automatic void queue_byte(input logic [7:0] b);
      byte_req_t item;
      item.command   = CMD_ABSORB;
      item.data_byte = b;
      pending.push_back(item);
   endfunction

   // data byte of a finish is don't-care, so it is randomized
   function automatic void queue_finish();
      byte_req_t item;
      item.command   = CMD_FINISH;
      item.data_byte = 8'($urandom_range(0, 255));
      pending.push_back(item);
   endfunction

   function automatic void queue_message(input int unsigned len);
      for (int unsigned i = 0; i < len; i++) queue_byte(8'($urandom_range(0, 255)));
      queue_finish();
   endfunction

   // sample both channels at the rising edge
   always @(posedge clock) begin
      byte_req_t    seen;
      digest_beat_t want;
      req_fire <= !reset && req_ch.valid && req_ch.ready;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            seen.command   = req_ch.command;
            seen.data_byte = req_ch.data_byte;
            hash_step(seen);
            accepted_reqs++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (digest_q.size() == 0) begin
               note_mismatch("unexpected digest word", 32'h0, rsp_ch.digest_word);
            end else begin
               want = digest_q.pop_front();
               if (rsp_ch.digest_word !== want.digest_word)
                  note_mismatch("digest_word", want.digest_word, rsp_ch.digest_word);
               if (rsp_ch.word_index !== want.word_index)
                  note_mismatch("word_index", 32'(want.word_index), 32'(rsp_ch.word_index));
               if (rsp_ch.last !== want.last)
                  note_mismatch("last", 32'(want.last), 32'(rsp_ch.last));
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
               $display("%0t ns: no transaction for %0d cycles", $time, IdleLimit);
               $display("== FAIL ==");
               $finish;
            end
         end
      end
   end

   // request driver: one transaction per entry of the pending queue
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_fire) pending.delete(0);
         if (req_ch.valid && !req_fire) begin
            // keep offering the same transaction
         end else if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending.size() > 0) begin
            if (pending.size() >= CalmItems && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 19) - 1;
               req_ch.valid <= 1'b0;
            end else begin
               req_ch.valid     <= 1'b1;
               req_ch.command   <= pending[0].command;
               req_ch.data_byte <= pending[0].data_byte;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // digest receiver; one long hold-off backs the block up into its input
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!pressure_done && accepted_reqs >= 30 && rsp_ch.valid) begin
         pressure_done = 1'b1;
         hold_left = HoldCycles - 1;
         rsp_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_ch.ready <= 1'b0;
      end else if (pending.size() >= CalmItems && $urandom_range(0, 9) == 0) begin
         recv_gap = $urandom_range(1, 19) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   initial begin
      int unsigned random_items;
      int unsigned message_count;
      int unsigned len;
      int unsigned boundary_lens [4];
      req_ch.valid     = 1'b0;
      req_ch.command   = CMD_ABSORB;
      req_ch.data_byte = 8'h00;
      rsp_ch.ready     = 1'b0;
      chain_st = InitChain;
      foreach (msg_words[i]) msg_words[i] = 32'h0;
      msg_bits = '0;

      // directed: empty message, "abc", byte extremes, finish right after finish
      queue_finish();
      queue_byte(8'h61);
      queue_byte(8'h62);
      queue_byte(8'h63);
      queue_finish();
      queue_byte(8'hff);
      queue_finish();
      queue_byte(8'h00);
      queue_byte(8'h7f);
      queue_byte(8'h80);
      queue_byte(8'h01);
      queue_finish();
      queue_finish();

      // random messages; the first ones sit on the padding limit and block edge
      boundary_lens = '{55, 56, 63, 64};
      random_items  = 0;
      message_count = 0;
      while (random_items < RandomItems) begin
         if (message_count < 4) begin
            len = boundary_lens[message_count];
         end else begin
            case ($urandom_range(0, 9))
               0: len = $urandom_range(50, 70);
               1: len = $urandom_range(100, 140);
               default: len = $urandom_range(0, 24);
            endcase
            // last message is trimmed so the item count lands on target
            if (len + 1 > RandomItems - random_items) len = RandomItems - random_items - 1;
         end
         queue_message(len);
         random_items += len + 1;
         message_count++;
      end

      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending.size() != 0) @(posedge clock);
      while (digest_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (failed) begin
         $display("== FAIL ==");
      end else begin
         $display("== PASS ==");
      end
      $finish;
   end

endmodule
